[design/sseg_pkg.sv]
// Shared types, constants and helper functions for the sound segment detector.
// No dependencies; every other design file depends on this package.
package sseg_pkg;

  localparam int MAX_FRAMES   = 65536;
  localparam int MAX_CHANNELS = 2;
  localparam int SAMPLE_BITS  = 16;

  localparam int FRAME_AW = $clog2(MAX_FRAMES);
  localparam int CNT_W    = FRAME_AW + 1;
  localparam int DEV_W    = SAMPLE_BITS + 1;
  localparam int SUM_W    = SAMPLE_BITS + FRAME_AW + 1;
  localparam int MAG_W    = SUM_W - 1;
  localparam int FRAC_W   = 16;
  localparam int THR_W    = DEV_W + FRAC_W;
  localparam int WORD_W   = SAMPLE_BITS * MAX_CHANNELS;
  localparam int OUT_W    = 16;
  localparam int RUN_W    = 8;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 16;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] REG_CHANNEL_COUNT    = 2'd0;
  localparam logic [CFG_IW-1:0] REG_SOUND_FRACTION   = 2'd1;
  localparam logic [CFG_IW-1:0] REG_SILENCE_FRACTION = 2'd2;
  localparam logic [CFG_IW-1:0] REG_SILENCE_RUN      = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [1:0]        RST_CHANNEL_COUNT    = 2'd1;
  localparam logic [FRAC_W-1:0] RST_SOUND_FRACTION   = 16'd24904;
  localparam logic [FRAC_W-1:0] RST_SILENCE_FRACTION = 16'd655;
  localparam logic [RUN_W-1:0]  RST_SILENCE_RUN      = 8'd5;

  // Operation codes of an input transaction.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // Absolute deviation of a sample from the channel mean.
  function automatic logic [DEV_W-1:0] abs_dev(input logic signed [SAMPLE_BITS-1:0] s,
                                               input logic signed [SAMPLE_BITS-1:0] m);
    logic signed [DEV_W-1:0] d;
    d = DEV_W'(s) - DEV_W'(m);
    abs_dev = d[DEV_W-1] ? DEV_W'(-d) : DEV_W'(d);
  endfunction

endpackage

[design/sseg_if.sv]
// Valid/ready channel interfaces for frame and segment transactions.
// Depends on sseg_pkg for field widths.
interface sseg_in_if;
  logic                               valid;
  logic                               ready;
  logic                               operation;
  logic                               first_frame;
  logic signed [sseg_pkg::SAMPLE_BITS-1:0] sample_left;
  logic signed [sseg_pkg::SAMPLE_BITS-1:0] sample_right;
  modport source (output valid, operation, first_frame, sample_left, sample_right,
                  input ready);
  modport sink (input valid, operation, first_frame, sample_left, sample_right,
                output ready);
endinterface

interface sseg_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [sseg_pkg::OUT_W-1:0]   segment_start;
  logic [sseg_pkg::OUT_W-1:0]   segment_end;
  logic [sseg_pkg::OUT_W-1:0]   segment_number;
  modport source (output valid, found, segment_start, segment_end, segment_number,
                  input ready);
  modport sink (input valid, found, segment_start, segment_end, segment_number,
                output ready);
endinterface

[design/sseg_div.sv]
// Restoring divider, one quotient bit per cycle, for the channel means.
// Depends on sseg_pkg for widths.
module sseg_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [sseg_pkg::MAG_W-1:0]   dividend,
  input  logic [sseg_pkg::CNT_W-1:0]   divisor,
  output logic [sseg_pkg::MAG_W-1:0]   quotient,
  output logic                         done
);
  import sseg_pkg::*;

  localparam int STEP_W = $clog2(MAG_W + 1);

  logic [CNT_W:0]      rem;
  logic [MAG_W-1:0]    work;
  logic [STEP_W-1:0]   steps;
  logic                busy;
  logic [CNT_W:0]      rem_sh;
  logic [CNT_W:0]      rem_sub;

  // Shift in the next dividend bit and try a subtraction.
  assign rem_sh  = {rem[CNT_W-1:0], work[MAG_W-1]};
  assign rem_sub = rem_sh - (CNT_W+1)'(divisor);
  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        rem   <= '0;
        work  <= dividend;
        steps <= STEP_W'(MAG_W);
      end else if (busy) begin
        if (rem_sh >= (CNT_W+1)'(divisor)) begin
          rem  <= rem_sub;
          work <= {work[MAG_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          work <= {work[MAG_W-2:0], 1'b0};
        end
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[design/sound_segment_detector.sv]
// Top level of the sound segment detector: frame store, sequencer and result register.
// Depends on sseg_pkg, the channel interfaces and sseg_div.

// Frames stream in at one per cycle while the block is idle. A segment request runs a
// small sequencer over the frame store, whose single read port has a registered
// output, so each visited frame is read before it is used. The first request after a
// load computes statistics: it sums the frames, divides each channel sum by the frame
// count, and finds the peak deviations. Every request then forms the four thresholds
// with one shared multiplier, scans for a trigger frame, and walks backward and forward
// from it. Input ready is low while a request runs; a finished result waits in the
// output register while new loads are taken.
module sound_segment_detector (
  input  logic                        clk,
  input  logic                        rst,
  sseg_in_if.sink                     frames,
  sseg_out_if.source                  segments,
  input  logic                        cfg_we,
  input  logic [sseg_pkg::CFG_IW-1:0] cfg_index,
  input  logic [sseg_pkg::CFG_DW-1:0] cfg_data
);
  import sseg_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUM, ST_DIV, ST_PEAK, ST_THR, ST_SCAN, ST_BACK, ST_FWD, ST_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [1:0]        channel_count;
  logic [FRAC_W-1:0] sound_fraction;
  logic [FRAC_W-1:0] silence_fraction;
  logic [RUN_W-1:0]  silence_run;

  // Block state.
  logic [CNT_W-1:0]              frame_total;
  logic [CNT_W-1:0]              scan_cursor;
  logic [OUT_W-1:0]              segment_counter;
  logic                          stats_ready;
  logic signed [SAMPLE_BITS-1:0] mean [MAX_CHANNELS];
  logic [DEV_W-1:0]              peak [MAX_CHANNELS];
  logic [THR_W-1:0]              trig_thr [MAX_CHANNELS];
  logic [THR_W-1:0]              sil_thr [MAX_CHANNELS];
  logic signed [SUM_W-1:0]       sum [MAX_CHANNELS];

  // Sequencer working registers.
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] trig_idx;
  logic [CNT_W-1:0] start_idx;
  logic [CNT_W-1:0] end_idx;
  logic             phase;
  logic             ch;
  logic [1:0]       step;
  logic [RUN_W-1:0] run;
  logic             seg_found;

  // Frame store and its read port.
  logic [WORD_W-1:0] frame_store [MAX_FRAMES];
  logic [WORD_W-1:0] rd_data;
  logic              mem_we;
  logic [FRAME_AW-1:0] wr_addr;

  // Divider hookup.
  logic             div_start;
  logic [MAG_W-1:0] div_dividend;
  logic [MAG_W-1:0] div_quotient;
  logic             div_done;

  logic signed [SAMPLE_BITS-1:0] s0, s1;
  logic [DEV_W-1:0]  dev0, dev1;
  logic              two_ch;
  logic              trig_hit, silent;
  logic              in_xfer, load_xfer, req_xfer;
  logic              load_drop;
  logic [THR_W-1:0]  mul_prod;
  logic [SAMPLE_BITS-1:0] q_low;

  sseg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (frame_total),
    .quotient (div_quotient),
    .done     (div_done)
  );

  // Handshake and load decoding.
  assign frames.ready = (state == ST_IDLE);
  assign in_xfer      = frames.valid && frames.ready;
  assign load_xfer    = in_xfer && (frames.operation == OP_LOAD);
  assign req_xfer     = in_xfer && (frames.operation == OP_REQUEST);
  assign load_drop    = !frames.first_frame && (frame_total == CNT_W'(MAX_FRAMES));
  assign mem_we       = load_xfer && !load_drop;
  assign wr_addr      = frames.first_frame ? '0 : frame_total[FRAME_AW-1:0];

  // Frame store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_store[wr_addr] <= {frames.sample_right, frames.sample_left};
    end
    rd_data <= frame_store[idx[FRAME_AW-1:0]];
  end

  // Per-frame evaluation of deviations against the thresholds.
  assign s0       = rd_data[SAMPLE_BITS-1:0];
  assign s1       = rd_data[WORD_W-1:SAMPLE_BITS];
  assign dev0     = abs_dev(s0, mean[0]);
  assign dev1     = abs_dev(s1, mean[1]);
  assign two_ch   = channel_count[1];
  assign trig_hit = ({dev0, 16'b0} >= trig_thr[0]) ||
                    (two_ch && ({dev1, 16'b0} >= trig_thr[1]));
  assign silent   = ({dev0, 16'b0} <= sil_thr[0]) &&
                    (!two_ch || ({dev1, 16'b0} <= sil_thr[1]));

  // Shared multiplier for the threshold products.
  assign mul_prod = (step[0] ? silence_fraction : sound_fraction) * peak[step[1]];

  // Magnitude of the channel sum and low quotient bits for the mean.
  assign div_dividend = sum[ch][SUM_W-1] ? MAG_W'(-sum[ch]) : MAG_W'(sum[ch]);
  assign q_low        = div_quotient[SAMPLE_BITS-1:0];

  // Sequencer, configuration and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      channel_count    <= RST_CHANNEL_COUNT;
      sound_fraction   <= RST_SOUND_FRACTION;
      silence_fraction <= RST_SILENCE_FRACTION;
      silence_run      <= RST_SILENCE_RUN;
      frame_total      <= '0;
      scan_cursor      <= '0;
      segment_counter  <= '0;
      stats_ready      <= 1'b0;
      mean[0]          <= '0;
      mean[1]          <= '0;
      peak[0]          <= '0;
      peak[1]          <= '0;
      div_start        <= 1'b0;
      segments.valid   <= 1'b0;
    end else begin
      div_start <= 1'b0;
      // The done state reloads the register itself when it is taken.
      if (segments.valid && segments.ready && state != ST_DONE) begin
        segments.valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_CHANNEL_COUNT:    channel_count    <= cfg_data[1:0];
          REG_SOUND_FRACTION:   sound_fraction   <= cfg_data[FRAC_W-1:0];
          REG_SILENCE_FRACTION: silence_fraction <= cfg_data[FRAC_W-1:0];
          REG_SILENCE_RUN:      silence_run      <= cfg_data[RUN_W-1:0];
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (load_xfer && !load_drop) begin
            frame_total     <= frames.first_frame ? CNT_W'(1) : frame_total + 1'b1;
            scan_cursor     <= '0;
            segment_counter <= '0;
            stats_ready     <= 1'b0;
          end
          if (req_xfer) begin
            phase <= 1'b0;
            idx   <= '0;
            step  <= '0;
            if (frame_total == '0) begin
              seg_found <= 1'b0;
              state     <= ST_DONE;
            end else if (!stats_ready) begin
              sum[0] <= '0;
              sum[1] <= '0;
              state  <= ST_SUM;
            end else begin
              state <= ST_THR;
            end
          end
        end

        // Accumulate both channel sums over the stored frames.
        ST_SUM: begin
          phase <= !phase;
          if (phase) begin
            sum[0] <= sum[0] + SUM_W'(s0);
            sum[1] <= sum[1] + SUM_W'(s1);
            if (idx == frame_total - 1'b1) begin
              ch    <= 1'b0;
              phase <= 1'b0;
              state <= ST_DIV;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end

        // Divide each channel sum by the frame count, truncating toward zero.
        ST_DIV: begin
          if (!phase) begin
            div_start <= 1'b1;
            phase     <= 1'b1;
          end else if (div_done) begin
            mean[ch] <= sum[ch][SUM_W-1] ? SAMPLE_BITS'(-q_low) : q_low;
            phase    <= 1'b0;
            if (ch) begin
              idx     <= '0;
              peak[0] <= '0;
              peak[1] <= '0;
              state   <= ST_PEAK;
            end else begin
              ch <= 1'b1;
            end
          end
        end

        // Largest absolute deviation per channel.
        ST_PEAK: begin
          phase <= !phase;
          if (phase) begin
            if (dev0 > peak[0]) peak[0] <= dev0;
            if (dev1 > peak[1]) peak[1] <= dev1;
            if (idx == frame_total - 1'b1) begin
              stats_ready <= 1'b1;
              step        <= '0;
              state       <= ST_THR;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end

        // Four threshold products through the shared multiplier.
        ST_THR: begin
          if (step[0]) sil_thr[step[1]] <= mul_prod;
          else         trig_thr[step[1]] <= mul_prod;
          step <= step + 1'b1;
          if (step == 2'd3) begin
            idx   <= scan_cursor;
            phase <= 1'b0;
            state <= ST_SCAN;
          end
        end

        // Search forward from the cursor for a trigger frame.
        ST_SCAN: begin
          if (!phase) begin
            if (idx >= frame_total) begin
              scan_cursor <= frame_total;
              seg_found   <= 1'b0;
              state       <= ST_DONE;
            end else begin
              phase <= 1'b1;
            end
          end else begin
            phase <= 1'b0;
            if (trig_hit) begin
              trig_idx <= idx;
              run      <= '0;
              state    <= ST_BACK;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end

        // Walk backward until enough silent frames or the first frame.
        ST_BACK: begin
          if (!phase) begin
            if (idx == '0 || run >= silence_run) begin
              start_idx <= idx;
              idx       <= trig_idx;
              run       <= '0;
              state     <= ST_FWD;
            end else begin
              phase <= 1'b1;
            end
          end else begin
            phase <= 1'b0;
            run   <= silent ? run + 1'b1 : '0;
            idx   <= idx - 1'b1;
          end
        end

        // Walk forward until enough silent frames or the last frame.
        ST_FWD: begin
          if (!phase) begin
            if (idx >= frame_total - 1'b1 || run >= silence_run) begin
              end_idx         <= idx;
              scan_cursor     <= idx + 1'b1;
              seg_found       <= 1'b1;
              segment_counter <= segment_counter + 1'b1;
              state           <= ST_DONE;
            end else begin
              phase <= 1'b1;
            end
          end else begin
            phase <= 1'b0;
            run   <= silent ? run + 1'b1 : '0;
            idx   <= idx + 1'b1;
          end
        end

        // Hand the result to the output register once it is free.
        ST_DONE: begin
          if (!segments.valid || segments.ready) begin
            segments.valid          <= 1'b1;
            segments.found          <= seg_found;
            segments.segment_start  <= seg_found ? start_idx[OUT_W-1:0] : '0;
            segments.segment_end    <= seg_found ? end_idx[OUT_W-1:0] : '0;
            segments.segment_number <= seg_found ? segment_counter - 1'b1 : '0;
            state                   <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

[design/sseg_checker.sv]
// Port-level checks on segment results, attached to the top level by bind.
// Depends on sseg_pkg for widths and on sound_segment_detector's ports.
module sseg_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       found,
  input logic [sseg_pkg::OUT_W-1:0] segment_start,
  input logic [sseg_pkg::OUT_W-1:0] segment_end,
  input logic [sseg_pkg::OUT_W-1:0] segment_number
);
  import sseg_pkg::*;

  // A pending result transaction is not withdrawn.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transaction");

  // An empty result carries all-zero fields.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> segment_start == '0 && segment_end == '0 &&
                            segment_number == '0)
    else $error("empty result carries nonzero fields");

  // A found segment never ends before it starts.
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> segment_start <= segment_end)
    else $error("segment end precedes start");

  // No result is offered right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind sound_segment_detector sseg_checker u_sseg_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (segments.valid),
  .out_ready      (segments.ready),
  .found          (segments.found),
  .segment_start  (segments.segment_start),
  .segment_end    (segments.segment_end),
  .segment_number (segments.segment_number)
);
